FILE: hdl/swas_pkg.sv
package swas_pkg;

  localparam int SEQ_W     = 16;
  localparam int WIN_W     = 6;
  localparam int RUN_LIMIT = 32;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE = 2'd0,
    CFG_FRAME_COUNT = 2'd1,
    CFG_REPEAT_MODE = 2'd2
  } swas_cfg_idx_e;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } swas_op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SEQ_W-1:0] ack_seq;
  } swas_in_t;

  typedef struct packed {
    logic [SEQ_W-1:0] send_seq;
    logic             is_retransmit;
    logic             send_valid;
    logic             ack_ignored;
    logic             transfer_done;
    logic             last_of_run;
  } swas_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_all;
    logic mark_ack;
    logic adv_step;
    logic refill_step;
    logic walk_init;
    logic walk_step;
    logic walk_sel;
    logic set_ignored;
    logic flush;
  } swas_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ack_in_win;
    logic ack_is_base;
    logic ack_is_newest;
    logic sel_repeat;
    logic adv_ok;
    logic refill_ok;
    logic walk_ok;
  } swas_sts_t;

endpackage

FILE: hdl/sliding_window_arq_sender.sv
// An item is accepted when start is high and busy is low; a frame leaves once the next frame
//   is found or the walk ends, and the last result is registered from the flush that ST_FINISH
//   raises after the walk exits. Steps: accept, check an ack, walk (advance, refill, resend)
//   one slot at a time until it exits, then finish; busy holds off a new item until then.
// Results are strobed by result_valid_o for one cycle each and cannot be stalled.
// Reset (rst_ni low, async): empty window at frame 0, acked flags clear, window 8, 1 frame, SR.
module sliding_window_arq_sender
  import swas_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item port
  input  logic                 start,
  output logic                 busy,
  input  swas_in_t             item_i,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // result port
  output logic                 result_valid_o,
  output swas_out_t            result_o
);

  swas_cmd_t cmd;
  swas_sts_t sts;

  // Controller: decode the event, then step the window walk one slot per cycle.
  swas_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Datapath: window pointers, per-slot acked flags, config and the result
  // holding stage that marks the final item of each run.
  swas_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ack_seq_i      (item_i.ack_seq),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: hdl/swas_dp.sv
module swas_dp
  import swas_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic [SEQ_W-1:0]     ack_seq_i,
  input  swas_cmd_t            cmd_i,
  output swas_sts_t            sts_o,
  output logic                 result_valid_o,
  output swas_out_t            result_o
);

  localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_LIM = (MAX_WINDOW < RUN_LIMIT) ? MAX_WINDOW : RUN_LIMIT;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);
  localparam logic [SLOT_W:0]   SLOT_SPAN = (SLOT_W + 1)'(MAX_WINDOW);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_LAST) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  logic [WIN_W-1:0]      win_size_q;
  logic [SEQ_W-1:0]      frame_cnt_q;
  logic                  repeat_q;

  logic [SEQ_W-1:0]      base_q, next_q, walk_seq_q, ack_q;
  logic [SLOT_W-1:0]     base_slot_q, next_slot_q, walk_slot_q;
  logic [MAX_WINDOW-1:0] flags_q;
  logic [CNT_W-1:0]      run_cnt_q;
  logic                  ignored_q;
  logic                  pend_valid_q;
  logic [SEQ_W-1:0]      pend_seq_q;
  logic                  pend_retx_q;
  logic                  res_valid_q;
  swas_out_t             res_q;

  logic [WIN_W-1:0]  eff_win;
  logic [SEQ_W-1:0]  outstanding, ack_off;
  logic [SLOT_W:0]   ack_sum;
  logic [SLOT_W-1:0] ack_slot, rd_slot;
  logic              rd_flag, run_room, done;
  logic              emit_now, emit_retx;
  logic [SEQ_W-1:0]  emit_seq;
  swas_out_t         res_d;

  always_comb begin
    if (win_size_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (win_size_q > WIN_W'(WIN_LIM)) begin
      eff_win = WIN_W'(WIN_LIM);
    end else begin
      eff_win = win_size_q;
    end
  end

  assign outstanding = next_q - base_q;
  assign run_room    = run_cnt_q < CNT_W'(RUN_LIMIT);
  assign done        = base_q >= frame_cnt_q;

  // ack lies less than one window past the base: one add and wrap
  assign ack_off  = ack_q - base_q;
  assign ack_sum  = {1'b0, base_slot_q} + {1'b0, ack_off[SLOT_W-1:0]};
  assign ack_slot = (ack_sum >= SLOT_SPAN) ? SLOT_W'(ack_sum - SLOT_SPAN)
                                           : ack_sum[SLOT_W-1:0];

  assign rd_slot = cmd_i.walk_sel ? walk_slot_q : base_slot_q;
  assign rd_flag = flags_q[rd_slot];

  assign sts_o.ack_in_win    = (ack_q >= base_q) && (ack_q < next_q);
  assign sts_o.ack_is_base   = ack_q == base_q;
  assign sts_o.ack_is_newest = ack_q == (next_q - 1'b1);
  assign sts_o.sel_repeat    = repeat_q;
  assign sts_o.adv_ok        = (base_q < next_q) && rd_flag;
  assign sts_o.refill_ok     = (next_q < frame_cnt_q) &&
                               (outstanding < {{(SEQ_W-WIN_W){1'b0}}, eff_win}) && run_room;
  assign sts_o.walk_ok       = (walk_seq_q < next_q) && run_room;

  always_comb begin
    emit_now  = 1'b0;
    emit_seq  = next_q;
    emit_retx = 1'b0;
    if (cmd_i.refill_step) begin
      emit_now = 1'b1;
    end else if (cmd_i.walk_step && (!repeat_q || !rd_flag)) begin
      emit_now  = 1'b1;
      emit_seq  = walk_seq_q;
      emit_retx = 1'b1;
    end
  end

  always_comb begin
    res_d.send_seq      = pend_seq_q;
    res_d.is_retransmit = pend_retx_q;
    res_d.send_valid    = 1'b1;
    res_d.ack_ignored   = ignored_q;
    res_d.transfer_done = done;
    res_d.last_of_run   = cmd_i.flush;
    if (cmd_i.flush && !pend_valid_q) begin
      res_d.send_seq      = '0;
      res_d.is_retransmit = 1'b0;
      res_d.send_valid    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q   <= WIN_W'(8);
      frame_cnt_q  <= SEQ_W'(1);
      repeat_q     <= 1'b1;
      base_q       <= '0;
      next_q       <= '0;
      base_slot_q  <= '0;
      next_slot_q  <= '0;
      flags_q      <= '0;
      run_cnt_q    <= '0;
      ignored_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_SIZE: win_size_q  <= cfg_wdata_i[WIN_W-1:0];
          CFG_FRAME_COUNT: frame_cnt_q <= cfg_wdata_i;
          CFG_REPEAT_MODE: repeat_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        run_cnt_q    <= '0;
        ignored_q    <= 1'b0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.clear_all) begin
        base_q      <= '0;
        next_q      <= '0;
        base_slot_q <= '0;
        next_slot_q <= '0;
        flags_q     <= '0;
      end
      if (cmd_i.mark_ack) begin
        flags_q[ack_slot] <= 1'b1;
      end
      if (cmd_i.adv_step) begin
        base_q      <= base_q + 1'b1;
        base_slot_q <= slot_inc(base_slot_q);
      end
      if (cmd_i.refill_step) begin
        flags_q[next_slot_q] <= 1'b0;
        next_q               <= next_q + 1'b1;
        next_slot_q          <= slot_inc(next_slot_q);
      end
      if (cmd_i.set_ignored) begin
        ignored_q <= 1'b1;
      end
      if (emit_now) begin
        run_cnt_q    <= run_cnt_q + 1'b1;
        pend_valid_q <= 1'b1;
      end
      res_valid_q <= (emit_now && pend_valid_q) || cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q <= cmd_i.load ? ack_seq_i : ack_q;
    if (cmd_i.walk_init) begin
      walk_seq_q  <= base_q;
      walk_slot_q <= base_slot_q;
    end else if (cmd_i.walk_step) begin
      walk_seq_q  <= walk_seq_q + 1'b1;
      walk_slot_q <= slot_inc(walk_slot_q);
    end
    if (emit_now) begin
      pend_seq_q  <= emit_seq;
      pend_retx_q <= emit_retx;
    end
    if ((emit_now && pend_valid_q) || cmd_i.flush) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: hdl/swas_ctrl.sv
module swas_ctrl
  import swas_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] opcode_i,
  input  swas_sts_t  sts_i,
  output swas_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_CHK,
    ST_ADVANCE,
    ST_REFILL,
    ST_RESEND,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && !busy_q) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            OP_START: begin
              cmd_o.clear_all = 1'b1;
              state_d         = ST_REFILL;
            end
            OP_ACK:     state_d = ST_ACK_CHK;
            OP_TIMEOUT: begin
              cmd_o.walk_init = 1'b1;
              state_d         = ST_RESEND;
            end
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_ACK_CHK: begin
        if (!sts_i.ack_in_win) begin
          cmd_o.set_ignored = 1'b1;
          state_d           = ST_FINISH;
        end else if (sts_i.ack_is_base) begin
          cmd_o.mark_ack = 1'b1;
          state_d        = ST_ADVANCE;
        end else begin
          cmd_o.mark_ack = sts_i.sel_repeat;
          if (sts_i.ack_is_newest) begin
            cmd_o.walk_init = 1'b1;
            state_d         = ST_RESEND;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_ADVANCE: begin
        if (sts_i.adv_ok) begin
          cmd_o.adv_step = 1'b1;
        end else begin
          state_d = ST_REFILL;
        end
      end
      ST_REFILL: begin
        if (sts_i.refill_ok) begin
          cmd_o.refill_step = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_RESEND: begin
        cmd_o.walk_sel = 1'b1;
        if (sts_i.walk_ok) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load) begin
        busy_q <= 1'b1;
      end else if (cmd_o.flush) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;

endmodule
